### hdl/ita_pkg.sv
// shared types, constants and character mapping for the integer to ascii converter
package ita_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int DATA_W = 64;
	localparam int TYPE_W = 3;
	localparam int CHAR_W = 7;
	localparam int POS_W = 5;
	localparam int DIGIT_W = 4;
	localparam int RADIX_W = 5;

	localparam logic [TYPE_W-1:0] TYPE_SDEC = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_UDEC = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_OCT = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_HEX_LOWER = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_HEX_UPPER = 3'd4;

	localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

	localparam logic [POS_W-1:0] POS_MAX = 5'd21;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [TYPE_W-1:0] req_type;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic [POS_W-1:0]  position;
		logic              last;
	} rsp_t;

	// control shared by every digit cell
	typedef struct packed {
		logic               clear;
		logic               dbl;
		logic               move;
		logic [RADIX_W-1:0] radix;
	} cell_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + CHAR_W'(d);
		end else begin
			digit_char = base + CHAR_W'(d) - CHAR_W'(10);
		end
	endfunction

endpackage

### hdl/integer_to_ascii_radix.sv
// integer to ascii converter: bit-serial radix conversion through a row of digit cells
// sequence: the conversion shifts all VALUE_WIDTH operand bits into the cells, then each character is emitted or
//   leading zero skipped in turn, up to (VALUE_WIDTH+2)/3 digits plus one for a minus sign
// items: one at a time, the next taken only after the last character of a string is emitted,
//   which any output stall delays
// reset: arst_n clears the controller and the output valid; cell digits clear on each item
module integer_to_ascii_radix #(
	parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ita_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ita_pkg::rsp_t rsp_data
);
	import ita_pkg::*;

	localparam int N_CELLS = (VALUE_WIDTH + 2) / 3;
	localparam int REM_W = $clog2(N_CELLS + 1);
	localparam int BIT_W = $clog2(VALUE_WIDTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [BIT_W-1:0]       bit_cnt_q;
	logic [REM_W-1:0]       remain_q;
	logic [POS_W-1:0]       pos_q;
	logic                   neg_q;
	logic                   started_q;
	logic                   upper_q;
	logic [RADIX_W-1:0]     radix_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	cell_ctrl_t         ctrl;
	logic [DIGIT_W-1:0] cell_digit [N_CELLS];
	logic               cell_carry [N_CELLS];

	logic [VALUE_WIDTH-1:0] in_val;
	logic                   in_neg;
	logic                   start;
	logic                   slot_free;
	logic                   is_last;
	logic                   skip;
	logic                   emit_neg;
	logic                   emit_dig;
	logic [DIGIT_W-1:0]     top_digit;

	assign in_val = req_data.value[VALUE_WIDTH-1:0];
	assign in_neg = (req_data.req_type == TYPE_SDEC) && in_val[VALUE_WIDTH-1];
	assign req_ready = (state_q == ST_IDLE);
	assign start = req_valid && req_ready && (req_data.req_type <= TYPE_HEX_UPPER);

	assign top_digit = cell_digit[N_CELLS-1];
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign is_last = (remain_q == REM_W'(1));
	// leading zeros leave the top of the row without a character
	assign skip = (state_q == ST_EMIT) && !neg_q && !started_q && (top_digit == '0) && !is_last;
	assign emit_neg = (state_q == ST_EMIT) && neg_q && slot_free;
	assign emit_dig = (state_q == ST_EMIT) && !neg_q && !skip && slot_free;

	assign ctrl.clear = start;
	assign ctrl.dbl = (state_q == ST_CONV);
	assign ctrl.move = skip || emit_dig;
	assign ctrl.radix = radix_q;

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		ita_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.carry_in    ((i == 0) ? val_q[VALUE_WIDTH-1] : cell_carry[(i == 0) ? 0 : i - 1]),
			.digit_below ((i == 0) ? DIGIT_W'(0) : cell_digit[(i == 0) ? 0 : i - 1]),
			.digit       (cell_digit[i]),
			.carry_out   (cell_carry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_cnt_q <= '0;
			remain_q <= '0;
			pos_q <= '0;
			neg_q <= 1'b0;
			started_q <= 1'b0;
			upper_q <= 1'b0;
			radix_q <= RADIX_DEC;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_neg || emit_dig) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						bit_cnt_q <= BIT_W'(VALUE_WIDTH - 1);
						remain_q <= REM_W'(N_CELLS);
						pos_q <= '0;
						neg_q <= in_neg;
						started_q <= 1'b0;
						upper_q <= (req_data.req_type == TYPE_HEX_UPPER);
						priority if (req_data.req_type == TYPE_SDEC ||
								req_data.req_type == TYPE_UDEC) begin
							radix_q <= RADIX_DEC;
						end else if (req_data.req_type == TYPE_OCT) begin
							radix_q <= RADIX_OCT;
						end else begin
							radix_q <= RADIX_HEX;
						end
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_W'(1);
					if (bit_cnt_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_neg) begin
						neg_q <= 1'b0;
						pos_q <= pos_q + POS_W'(1);
					end
					if (ctrl.move) begin
						remain_q <= remain_q - REM_W'(1);
					end
					if (emit_dig) begin
						started_q <= 1'b1;
						pos_q <= pos_q + POS_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operand and output payload
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
		end else if (state_q == ST_CONV) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
		end
		if (emit_neg) begin
			rsp_q.character <= CHAR_MINUS;
			rsp_q.position <= pos_q;
			rsp_q.last <= 1'b0;
		end else if (emit_dig) begin
			rsp_q.character <= digit_char(top_digit, upper_q);
			rsp_q.position <= pos_q;
			rsp_q.last <= is_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule

### hdl/ita_cell.sv
// one digit cell: clears, doubles its digit modulo the radix with a bit from below, or takes the lower digit
module ita_cell (
	input  logic                       clk,
	input  ita_pkg::cell_ctrl_t        ctrl,
	input  logic                       carry_in,
	input  logic [ita_pkg::DIGIT_W-1:0] digit_below,
	output logic [ita_pkg::DIGIT_W-1:0] digit,
	output logic                       carry_out
);
	import ita_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [RADIX_W-1:0] doubled;
	logic [RADIX_W-1:0] half;

	assign half = ctrl.radix >> 1;
	assign doubled = {digit_q, carry_in};
	// carry depends only on the stored digit and the radix, so nothing ripples along the row
	assign carry_out = RADIX_W'(digit_q) >= half;
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dbl) begin
			if (carry_out) begin
				digit_q <= DIGIT_W'(doubled - ctrl.radix);
			end else begin
				digit_q <= doubled[DIGIT_W-1:0];
			end
		end else if (ctrl.move) begin
			digit_q <= digit_below;
		end
	end

endmodule

### hdl/ita_checker.sv
// port-level checks for the integer to ascii converter, bound to the top level
module ita_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input ita_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ita_pkg::rsp_t rsp_data
);
	import ita_pkg::*;

	// a stalled character holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("character changed while stalled");

	// a minus sign only leads the string
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.character == CHAR_MINUS |-> rsp_data.position == '0 &&
		!rsp_data.last)
		else $error("minus sign away from the front");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.position <= POS_MAX)
		else $error("position out of range");

	// a valid request starts a conversion that blocks the next item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.req_type <= TYPE_HEX_UPPER |=> !req_ready)
		else $error("item taken during conversion");

endmodule

bind integer_to_ascii_radix ita_checker u_ita_checker (.*);

### dv/ita_text_checker.sv
// checker for the integer to ascii converter: predicts each string and compares every character
module ita_text_checker #(
	parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  ita_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  ita_pkg::rsp_t rsp_data,
	output int            fail_count,
	output int            chars_waiting,
	output int            chars_checked,
	output int            strings_checked
);
	import ita_pkg::*;

	localparam int STORE_DEPTH = 22;
	localparam logic [63:0] VALUE_MASK = (VALUE_WIDTH >= 64) ? {64{1'b1}} :
		((64'd1 << VALUE_WIDTH) - 64'd1);

	rsp_t expected_chars[$];

	// builds the expected string of one item, most significant character first
	function automatic void queue_text(input req_t item);
		logic [63:0] mag;
		logic [63:0] base;
		logic [3:0]  digits [0:STORE_DEPTH-1];
		int          ndig;
		int          total;
		int          slot;
		int          pos;
		logic        neg;
		logic        upper;
		rsp_t        ch;
		mag = item.value & VALUE_MASK;
		neg = 1'b0;
		upper = 1'b0;
		base = 64'd10;
		case (item.req_type)
			TYPE_SDEC: begin
				// magnitude of a negative value by two's complement negation
				if (mag[VALUE_WIDTH-1]) begin
					neg = 1'b1;
					mag = (~mag + 64'd1) & VALUE_MASK;
				end
			end
			TYPE_UDEC: base = 64'd10;
			TYPE_OCT: base = 64'd8;
			TYPE_HEX_LOWER: base = 64'd16;
			TYPE_HEX_UPPER: begin
				base = 64'd16;
				upper = 1'b1;
			end
			default: return;
		endcase
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % base);
			ndig++;
			mag = mag / base;
		end while (mag != 64'd0 && ndig < STORE_DEPTH);
		total = ndig + (neg ? 1 : 0);
		pos = 0;
		if (neg) begin
			ch.character = CHAR_MINUS;
			ch.position = POS_W'(pos);
			ch.last = (total == 1);
			expected_chars.push_back(ch);
			pos++;
		end
		for (slot = ndig - 1; slot >= 0; slot--) begin
			if (digits[slot] < 4'd10) begin
				ch.character = CHAR_ZERO + CHAR_W'(digits[slot]);
			end else begin
				ch.character = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) +
					CHAR_W'(digits[slot]) - CHAR_W'(10);
			end
			ch.position = POS_W'(pos);
			ch.last = (pos + 1 == total);
			expected_chars.push_back(ch);
			pos++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			expected_chars.delete();
			fail_count <= 0;
			chars_waiting <= 0;
			chars_checked <= 0;
			strings_checked <= 0;
		end else begin
			// compare before predicting so a result never matches its own item
			if (rsp_valid && rsp_ready) begin
				if (expected_chars.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected character %h pos %0d last %b",
							rsp_data.character, rsp_data.position, rsp_data.last);
					end
					fail_count <= fail_count + 1;
				end else begin
					want = expected_chars.pop_front();
					if (want !== rsp_data) begin
						if (fail_count < 10) begin
							$display({"mismatch: expected char %h pos %0d last %b, ",
								"got char %h pos %0d last %b"},
								want.character, want.position, want.last,
								rsp_data.character, rsp_data.position, rsp_data.last);
						end
						fail_count <= fail_count + 1;
					end
					chars_checked <= chars_checked + 1;
					if (want.last) begin
						strings_checked <= strings_checked + 1;
					end
				end
			end
			if (req_valid && req_ready) begin
				queue_text(req_data);
			end
			chars_waiting <= expected_chars.size();
		end
	end

endmodule

### dv/integer_to_ascii_radix_tb.sv
// testbench top for the integer to ascii converter: stimulus, idling phases and verdict
module integer_to_ascii_radix_tb;
	import ita_pkg::*;

	localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_PHASE = 82;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	int fail_count;
	int chars_waiting;
	int chars_checked;
	int strings_checked;

	int send_idle_pct;
	int ready_stall_pct;
	bit hold_req;
	int conversions_sent;
	int ignored_sent;

	integer_to_ascii_radix #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	ita_text_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.fail_count(fail_count),
		.chars_waiting(chars_waiting),
		.chars_checked(chars_checked),
		.strings_checked(strings_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
			end
		end
	end

	// offers one item at a falling edge and returns at the falling edge after acceptance
	task automatic send_text(input logic [DATA_W-1:0] value, input logic [TYPE_W-1:0] kind);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= '{value: value, req_type: kind};
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		if (kind > TYPE_HEX_UPPER) begin
			ignored_sent++;
		end else begin
			conversions_sent++;
		end
	endtask

	function automatic logic [DATA_W-1:0] random_value();
		logic [DATA_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = v;
			1: v = DATA_W'($urandom_range(0, 99));
			2: v = v >> $urandom_range(0, 63);
			3: v = -DATA_W'($urandom_range(1, 1000));
			4: v = (64'd1 << $urandom_range(0, 63)) - DATA_W'($urandom_range(0, 1));
			default: v = v | 64'h8000_0000_0000_0000;
		endcase
		return v;
	endfunction

	task automatic send_random(input int count);
		int sent;
		logic [TYPE_W-1:0] kind;
		sent = 0;
		while (sent < count) begin
			// a few unused selectors mixed in as noise
			if ($urandom_range(0, 99) < 4) begin
				kind = TYPE_W'($urandom_range(5, 7));
			end else begin
				kind = TYPE_W'($urandom_range(0, 4));
				sent++;
			end
			send_text(random_value(), kind);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		send_idle_pct = 0;
		ready_stall_pct = 0;
		hold_req = 1'b0;
		conversions_sent = 0;
		ignored_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero and all ones in every format, signed extremes, letters, unused selectors
		send_text(64'd0, TYPE_SDEC);
		send_text(64'd0, TYPE_UDEC);
		send_text(64'd0, TYPE_OCT);
		send_text(64'd0, TYPE_HEX_LOWER);
		send_text(64'd0, TYPE_HEX_UPPER);
		send_text({64{1'b1}}, TYPE_SDEC);
		send_text({64{1'b1}}, TYPE_UDEC);
		send_text({64{1'b1}}, TYPE_OCT);
		send_text({64{1'b1}}, TYPE_HEX_LOWER);
		send_text({64{1'b1}}, TYPE_HEX_UPPER);
		send_text(64'h8000_0000_0000_0000, TYPE_SDEC);
		send_text(64'h7fff_ffff_ffff_ffff, TYPE_SDEC);
		send_text(64'd1, TYPE_SDEC);
		send_text(64'hffff_ffff_ffff_fff6, TYPE_SDEC);
		send_text(64'hfedc_ba98_7654_3210, TYPE_HEX_LOWER);
		send_text(64'hfedc_ba98_7654_3210, TYPE_HEX_UPPER);
		send_text(64'h0000_0000_00ab_cdef, TYPE_HEX_UPPER);
		send_text(64'd10000000000000000000, TYPE_UDEC);
		send_text(64'd9, TYPE_UDEC);
		send_text(64'd8, TYPE_OCT);
		send_text(64'h8000_0000_0000_0000, TYPE_OCT);
		send_text(64'h1234_5678_9abc_def0, 3'd5);
		send_text(64'h0000_0000_0000_0001, 3'd6);
		send_text({64{1'b1}}, 3'd7);

		// random phases: free flow, slow sender, slow receiver, both
		send_random(ITEMS_PER_PHASE);
		send_idle_pct = 85;
		send_random(ITEMS_PER_PHASE);
		send_idle_pct = 0;
		ready_stall_pct = 85;
		send_random(ITEMS_PER_PHASE);
		send_idle_pct = 18;
		ready_stall_pct = 18;
		send_random(ITEMS_PER_PHASE);

		// back pressure: receiver holds off while items keep coming
		send_idle_pct = 0;
		ready_stall_pct = 0;
		hold_req = 1'b1;
		send_random(ITEMS_PER_PHASE);

		req_valid <= 1'b0;
		while (chars_waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d conversions and %0d unused selectors", conversions_sent, ignored_sent);
		$display("checked %0d characters in %0d strings", chars_checked, strings_checked);
		if (fail_count == 0 && chars_waiting == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d failures, %0d characters never arrived", fail_count, chars_waiting);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/ita_pkg.sv
hdl/ita_cell.sv
hdl/integer_to_ascii_radix.sv
hdl/ita_checker.sv
dv/ita_text_checker.sv
dv/integer_to_ascii_radix_tb.sv
